FILE: src/vtcd_pkg.sv
// ----------------------------------------------------------------------------
// vtcd_pkg
// shared types, widths and helpers of the vertex transform / clip / divide core
// ----------------------------------------------------------------------------
package vtcd_pkg;

  // clip coordinate width (signed), magnitude width, quotient widths
  localparam int CW  = 51;
  localparam int MW  = 50;
  localparam int FQ  = 16;
  localparam int IW  = 31;
  localparam int NQ  = 31;

  // 1/w starts with the numerator bits above the quotient window
  localparam logic [MW-1:0] INV_R0      = MW'(2048);
  localparam logic [IW-1:0] INV_SAT_VAL = {IW{1'b1}};

  // register map
  typedef enum logic [2:0] {
    REG_ROW_X  = 3'd0,
    REG_ROW_Y  = 3'd1,
    REG_ROW_Z  = 3'd2,
    REG_ROW_W  = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5,
    REG_MODE   = 3'd6
  } reg_idx_t;

  localparam logic [63:0] ROW_X_RST  = 64'd1024;
  localparam logic [63:0] ROW_Y_RST  = 64'd67108864;
  localparam logic [63:0] ROW_Z_RST  = 64'd4398046511104;
  localparam logic [63:0] ROW_W_RST  = 64'd288230376151711744;
  localparam logic [12:0] WIDTH_RST  = 13'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;

  // item moving through the divide stages
  typedef struct packed {
    logic                 valid;
    logic                 vis;
    logic                 sat;
    logic [2:0]           neg;
    logic [MW-1:0]        d;
    logic [2:0][MW-1:0]   rf;
    logic [2:0][FQ-1:0]   qf;
    logic [MW-1:0]        ri;
    logic [IW-1:0]        qi;
    logic signed [31:0]   u;
    logic signed [31:0]   v;
  } div_item_t;

  // saturate a 48-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    logic signed [31:0] res;
    if (x > 48'sh0000_7FFF_FFFF)       res = 32'sh7FFF_FFFF;
    else if (x < -48'sh0000_8000_0000) res = -32'sh8000_0000;
    else                               res = x[31:0];
    return res;
  endfunction

endpackage

FILE: src/vertex_transform_clip_divide_core.sv
// an accepted start flows through the transform, divider and finish registers
// throughput: one vertex per cycle, busy stays low outside reset
// the 31-stage restoring divider for 1/w sets the depth of the pipe
// reset (rst_n low, synchronous) empties the pipe and restores the registers
// results are not held: out_valid marks each beat for one cycle
// ----------------------------------------------------------------------------
// vertex_transform_clip_divide_core
// vertex transform, clip test, perspective divide and viewport map
// ----------------------------------------------------------------------------
module vertex_transform_clip_divide_core (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_local_x,
  input  logic signed [31:0] in_local_y,
  input  logic signed [31:0] in_local_z,
  input  logic signed [31:0] in_offset_x,
  input  logic signed [31:0] in_offset_y,
  input  logic signed [31:0] in_offset_z,
  input  logic signed [31:0] in_tex_u,
  input  logic signed [31:0] in_tex_v,
  // result channel
  output logic               out_valid,
  output logic               out_visible,
  output logic signed [31:0] out_screen_x,
  output logic signed [31:0] out_screen_y,
  output logic signed [31:0] out_depth,
  output logic [30:0]        out_inv_w,
  output logic signed [31:0] out_out_u,
  output logic signed [31:0] out_out_v,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  // register file
  logic [3:0][63:0] row_r;
  logic [12:0]      width_r, height_r;
  logic             mode_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= vtcd_pkg::ROW_X_RST;
      row_r[1] <= vtcd_pkg::ROW_Y_RST;
      row_r[2] <= vtcd_pkg::ROW_Z_RST;
      row_r[3] <= vtcd_pkg::ROW_W_RST;
      width_r  <= vtcd_pkg::WIDTH_RST;
      height_r <= vtcd_pkg::HEIGHT_RST;
      mode_r   <= 1'b0;
    end else if (wr_en) begin
      unique case (vtcd_pkg::reg_idx_t'(paddr[5:3]))
        vtcd_pkg::REG_ROW_X:  row_r[0] <= pwdata;
        vtcd_pkg::REG_ROW_Y:  row_r[1] <= pwdata;
        vtcd_pkg::REG_ROW_Z:  row_r[2] <= pwdata;
        vtcd_pkg::REG_ROW_W:  row_r[3] <= pwdata;
        vtcd_pkg::REG_WIDTH:  width_r  <= pwdata[12:0];
        vtcd_pkg::REG_HEIGHT: height_r <= pwdata[12:0];
        vtcd_pkg::REG_MODE:   mode_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (vtcd_pkg::reg_idx_t'(paddr[5:3]))
      vtcd_pkg::REG_ROW_X:  prdata = row_r[0];
      vtcd_pkg::REG_ROW_Y:  prdata = row_r[1];
      vtcd_pkg::REG_ROW_Z:  prdata = row_r[2];
      vtcd_pkg::REG_ROW_W:  prdata = row_r[3];
      vtcd_pkg::REG_WIDTH:  prdata = {51'b0, width_r};
      vtcd_pkg::REG_HEIGHT: prdata = {51'b0, height_r};
      vtcd_pkg::REG_MODE:   prdata = {63'b0, mode_r};
      default:              prdata = '0;
    endcase
  end

  // command accept
  logic acc;
  assign busy = !rst_n;
  assign acc  = start && !busy;

  // front end
  vtcd_pkg::div_item_t pipe [vtcd_pkg::NQ+1];

  vtcd_transform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .local_x  (in_local_x),
    .local_y  (in_local_y),
    .local_z  (in_local_z),
    .offset_x (in_offset_x),
    .offset_y (in_offset_y),
    .offset_z (in_offset_z),
    .tex_u    (in_tex_u),
    .tex_v    (in_tex_v),
    .rows     (row_r),
    .item     (pipe[0])
  );

  // divider stages: ndc lanes run the first 16, 1/w runs all
  for (genvar k = 0; k < vtcd_pkg::NQ; k++) begin : g_div
    vtcd_div_step #(
      .DO_FRAC (k < vtcd_pkg::FQ)
    ) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .item_i (pipe[k]),
      .item_o (pipe[k+1])
    );
  end

  // back end
  vtcd_finish u_fin (
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (pipe[vtcd_pkg::NQ]),
    .width        (width_r),
    .height       (height_r),
    .mode         (mode_r),
    .res_valid    (out_valid),
    .res_visible  (out_visible),
    .res_screen_x (out_screen_x),
    .res_screen_y (out_screen_y),
    .res_depth    (out_depth),
    .res_inv_w    (out_inv_w),
    .res_u        (out_out_u),
    .res_v        (out_out_v)
  );

endmodule

FILE: src/vtcd_transform.sv
// ----------------------------------------------------------------------------
// vtcd_transform
// translation, matrix products, row sums and clip test with divider setup
// ----------------------------------------------------------------------------
module vtcd_transform (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    acc,
  input  logic signed [31:0]      local_x,
  input  logic signed [31:0]      local_y,
  input  logic signed [31:0]      local_z,
  input  logic signed [31:0]      offset_x,
  input  logic signed [31:0]      offset_y,
  input  logic signed [31:0]      offset_z,
  input  logic signed [31:0]      tex_u,
  input  logic signed [31:0]      tex_v,
  input  logic [3:0][63:0]        rows,
  output vtcd_pkg::div_item_t     item
);

  // stage 1: world position
  logic                     s1_vld_r;
  logic signed [2:0][32:0]  s1_p_r;
  logic signed [31:0]       s1_u_r, s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= acc;
  end

  always_ff @(posedge clk) begin
    s1_p_r[0] <= 33'(local_x) + 33'(offset_x);
    s1_p_r[1] <= 33'(local_y) + 33'(offset_y);
    s1_p_r[2] <= 33'(local_z) + 33'(offset_z);
    s1_u_r    <= tex_u;
    s1_v_r    <= tex_v;
  end

  // stage 2: weight products
  logic                          s2_vld_r;
  logic signed [3:0][2:0][48:0]  s2_prod_r, s2_prod_nxt;
  logic signed [3:0][15:0]       s2_w3_r;
  logic signed [31:0]            s2_u_r, s2_v_r;

  always_comb begin
    logic signed [15:0] w;
    logic signed [32:0] p;
    for (int r = 0; r < 4; r++) begin
      for (int i = 0; i < 3; i++) begin
        w = rows[r][16*i +: 16];
        p = s1_p_r[i];
        s2_prod_nxt[r][i] = 49'(w) * 49'(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    s2_prod_r <= s2_prod_nxt;
    for (int r = 0; r < 4; r++) s2_w3_r[r] <= rows[r][63:48];
    s2_u_r <= s1_u_r;
    s2_v_r <= s1_v_r;
  end

  // stage 3: row sums give clip coordinates
  logic                                s3_vld_r;
  logic signed [3:0][vtcd_pkg::CW-1:0] s3_c_r, s3_c_nxt;
  logic signed [31:0]                  s3_u_r, s3_v_r;

  always_comb begin
    logic signed [vtcd_pkg::CW-1:0] t3;
    for (int r = 0; r < 4; r++) begin
      t3 = vtcd_pkg::CW'($signed(s2_w3_r[r])) <<< 16;
      s3_c_nxt[r] = vtcd_pkg::CW'($signed(s2_prod_r[r][0]))
                  + vtcd_pkg::CW'($signed(s2_prod_r[r][1]))
                  + vtcd_pkg::CW'($signed(s2_prod_r[r][2])) + t3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    s3_c_r <= s3_c_nxt;
    s3_u_r <= s2_u_r;
    s3_v_r <= s2_v_r;
  end

  // stage 4: clip test and divider setup
  vtcd_pkg::div_item_t item_r, item_nxt;

  always_comb begin
    logic signed [vtcd_pkg::CW-1:0] cw, cr, mag;
    logic                           in_all;
    cw     = s3_c_r[3];
    in_all = 1'b1;
    item_nxt = '0;
    for (int r = 0; r < 3; r++) begin
      cr = s3_c_r[r];
      if (!(cr < cw && cr > -cw)) in_all = 1'b0;
      mag = cr[vtcd_pkg::CW-1] ? -cr : cr;
      item_nxt.rf[r]  = mag[vtcd_pkg::MW-1:0];
      item_nxt.neg[r] = cr[vtcd_pkg::CW-1];
    end
    item_nxt.valid = s3_vld_r;
    item_nxt.vis   = in_all;
    item_nxt.d     = cw[vtcd_pkg::MW-1:0];
    item_nxt.sat   = (cw <= vtcd_pkg::CW'(2048));
    item_nxt.ri    = vtcd_pkg::INV_R0;
    item_nxt.u     = s3_u_r;
    item_nxt.v     = s3_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) item_r.valid <= 1'b0;
    else        item_r.valid <= item_nxt.valid;
  end

  always_ff @(posedge clk) begin
    item_r.vis <= item_nxt.vis;
    item_r.sat <= item_nxt.sat;
    item_r.neg <= item_nxt.neg;
    item_r.d   <= item_nxt.d;
    item_r.rf  <= item_nxt.rf;
    item_r.qf  <= item_nxt.qf;
    item_r.ri  <= item_nxt.ri;
    item_r.qi  <= item_nxt.qi;
    item_r.u   <= item_nxt.u;
    item_r.v   <= item_nxt.v;
  end

  assign item = item_r;

endmodule

FILE: src/vtcd_div_step.sv
// ----------------------------------------------------------------------------
// vtcd_div_step
// one restoring-division bit for the 1/w lane, and for the three ndc lanes when DO_FRAC is set
// ----------------------------------------------------------------------------
module vtcd_div_step #(
  parameter bit DO_FRAC = 1'b1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vtcd_pkg::div_item_t  item_i,
  output vtcd_pkg::div_item_t  item_o
);

  vtcd_pkg::div_item_t item_r, item_nxt;

  // shift, compare, subtract on each lane
  always_comb begin
    logic [vtcd_pkg::MW:0] r2;
    item_nxt = item_i;
    if (DO_FRAC) begin
      for (int k = 0; k < 3; k++) begin
        r2 = {item_i.rf[k], 1'b0};
        if (r2 >= {1'b0, item_i.d}) begin
          r2 = r2 - {1'b0, item_i.d};
          item_nxt.qf[k] = {item_i.qf[k][vtcd_pkg::FQ-2:0], 1'b1};
        end else begin
          item_nxt.qf[k] = {item_i.qf[k][vtcd_pkg::FQ-2:0], 1'b0};
        end
        item_nxt.rf[k] = r2[vtcd_pkg::MW-1:0];
      end
    end
    r2 = {item_i.ri, 1'b0};
    if (r2 >= {1'b0, item_i.d}) begin
      r2 = r2 - {1'b0, item_i.d};
      item_nxt.qi = {item_i.qi[vtcd_pkg::IW-2:0], 1'b1};
    end else begin
      item_nxt.qi = {item_i.qi[vtcd_pkg::IW-2:0], 1'b0};
    end
    item_nxt.ri = r2[vtcd_pkg::MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) item_r.valid <= 1'b0;
    else        item_r.valid <= item_nxt.valid;
  end

  always_ff @(posedge clk) begin
    item_r.vis <= item_nxt.vis;
    item_r.sat <= item_nxt.sat;
    item_r.neg <= item_nxt.neg;
    item_r.d   <= item_nxt.d;
    item_r.rf  <= item_nxt.rf;
    item_r.qf  <= item_nxt.qf;
    item_r.ri  <= item_nxt.ri;
    item_r.qi  <= item_nxt.qi;
    item_r.u   <= item_nxt.u;
    item_r.v   <= item_nxt.v;
  end

  assign item_o = item_r;

endmodule

FILE: src/vtcd_finish.sv
// ----------------------------------------------------------------------------
// vtcd_finish
// viewport scaling, texture scaling by 1/w with saturation in mode 0, result register
// ----------------------------------------------------------------------------
module vtcd_finish (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vtcd_pkg::div_item_t  item,
  input  logic [12:0]          width,
  input  logic [12:0]          height,
  input  logic                 mode,
  output logic                 res_valid,
  output logic                 res_visible,
  output logic signed [31:0]   res_screen_x,
  output logic signed [31:0]   res_screen_y,
  output logic signed [31:0]   res_depth,
  output logic [30:0]          res_inv_w,
  output logic signed [31:0]   res_u,
  output logic signed [31:0]   res_v
);

  // multiply stage
  logic               m_vld_r, m_vis_r;
  logic signed [30:0] m_mx_r, m_my_r, m_mx_nxt, m_my_nxt;
  logic signed [16:0] m_z_r, m_z_nxt;
  logic [30:0]        m_inv_r, m_inv_nxt;
  logic signed [63:0] m_mu_r, m_mv_r, m_mu_nxt, m_mv_nxt;
  logic signed [31:0] m_u_r, m_v_r;

  always_comb begin
    logic signed [16:0] nx, ny;
    logic signed [13:0] sw, sh;
    logic signed [31:0] inv_s;
    nx = item.neg[0] ? -{1'b0, item.qf[0]} : {1'b0, item.qf[0]};
    ny = item.neg[1] ? -{1'b0, item.qf[1]} : {1'b0, item.qf[1]};
    m_z_nxt = item.neg[2] ? -{1'b0, item.qf[2]} : {1'b0, item.qf[2]};
    sw = {1'b0, width};
    sh = {1'b0, height};
    m_mx_nxt = 31'(nx) * 31'(sw);
    m_my_nxt = 31'(ny) * 31'(sh);
    m_inv_nxt = item.sat ? vtcd_pkg::INV_SAT_VAL : item.qi;
    inv_s = {1'b0, m_inv_nxt};
    m_mu_nxt = 64'(item.u) * 64'(inv_s);
    m_mv_nxt = 64'(item.v) * 64'(inv_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else        m_vld_r <= item.valid;
  end

  always_ff @(posedge clk) begin
    m_vis_r <= item.vis;
    m_mx_r  <= m_mx_nxt;
    m_my_r  <= m_my_nxt;
    m_z_r   <= m_z_nxt;
    m_inv_r <= m_inv_nxt;
    m_mu_r  <= m_mu_nxt;
    m_mv_r  <= m_mv_nxt;
    m_u_r   <= item.u;
    m_v_r   <= item.v;
  end

  // output stage
  logic               o_vld_r, o_vis_r, o_vis_nxt;
  logic signed [31:0] o_sx_r, o_sy_r, o_z_r, o_u_r, o_v_r;
  logic signed [31:0] o_sx_nxt, o_sy_nxt, o_z_nxt, o_u_nxt, o_v_nxt;
  logic [30:0]        o_inv_r, o_inv_nxt;

  always_comb begin
    logic [11:0]        offx, offy;
    logic signed [29:0] hx, hy;
    logic signed [47:0] su, sv;
    offx = (width  == 13'd0) ? 12'd0 : 12'((width  - 13'd1) >> 1);
    offy = (height == 13'd0) ? 12'd0 : 12'((height - 13'd1) >> 1);
    hx = 30'(m_mx_r >>> 1);
    hy = 30'(m_my_r >>> 1);
    su = 48'(m_mu_r >>> 16);
    sv = 48'(m_mv_r >>> 16);
    o_vis_nxt = m_vis_r;
    o_sx_nxt  = 32'(hx) + $signed({4'b0, offx, 16'b0});
    o_sy_nxt  = 32'(hy) + $signed({4'b0, offy, 16'b0});
    o_z_nxt   = 32'(m_z_r);
    o_inv_nxt = m_inv_r;
    o_u_nxt   = mode ? m_u_r : vtcd_pkg::sat32(su);
    o_v_nxt   = mode ? m_v_r : vtcd_pkg::sat32(sv);
    // rejected vertex: all fields zero
    if (!m_vis_r) begin
      o_sx_nxt  = '0;
      o_sy_nxt  = '0;
      o_z_nxt   = '0;
      o_inv_nxt = '0;
      o_u_nxt   = '0;
      o_v_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else        o_vld_r <= m_vld_r;
  end

  always_ff @(posedge clk) begin
    o_vis_r <= o_vis_nxt;
    o_sx_r  <= o_sx_nxt;
    o_sy_r  <= o_sy_nxt;
    o_z_r   <= o_z_nxt;
    o_inv_r <= o_inv_nxt;
    o_u_r   <= o_u_nxt;
    o_v_r   <= o_v_nxt;
  end

  assign res_valid    = o_vld_r;
  assign res_visible  = o_vis_r;
  assign res_screen_x = o_sx_r;
  assign res_screen_y = o_sy_r;
  assign res_depth    = o_z_r;
  assign res_inv_w    = o_inv_r;
  assign res_u        = o_u_r;
  assign res_v        = o_v_r;

endmodule

FILE: src/vtcd_checker.sv
// ----------------------------------------------------------------------------
// vtcd_checker
// port-level checks of the vertex transform / clip / divide core
// ----------------------------------------------------------------------------
module vtcd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input logic               out_visible,
  input logic signed [31:0] out_screen_x,
  input logic signed [31:0] out_screen_y,
  input logic signed [31:0] out_depth,
  input logic [30:0]        out_inv_w,
  input logic signed [31:0] out_out_u,
  input logic signed [31:0] out_out_v
);

  // pipe never stalls once out of reset
  a_no_busy: assert property (@(posedge clk) rst_n |-> !busy)
    else $error("busy high outside reset");

  // reset empties the pipe
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // rejected vertex carries zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_screen_x == 0 && out_screen_y == 0 &&
      out_depth == 0 && out_inv_w == 0 && out_out_u == 0 && out_out_v == 0)
    else $error("rejected vertex with nonzero fields");

  // depth of a visible vertex lies inside (-1, 1)
  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_visible |-> out_depth < 32'sd65536 && out_depth > -32'sd65536)
    else $error("depth outside unit range");

endmodule

bind vertex_transform_clip_divide_core vtcd_checker u_vtcd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_visible  (out_visible),
  .out_screen_x (out_screen_x),
  .out_screen_y (out_screen_y),
  .out_depth    (out_depth),
  .out_inv_w    (out_inv_w),
  .out_out_u    (out_out_u),
  .out_out_v    (out_out_v)
);
